// ----- design/eodg_pkg.sv -----
`default_nettype none

package eodg_pkg;

   // Configuration
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int CFG_W             = 11;
   localparam int PADDR_W           = 3;
   localparam int PDATA_W           = 32;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [CFG_W-1:0] MIN_SIZE     = 11'd5;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // Payload widths
   localparam int PIX_W  = 8;
   localparam int POS_W  = 10;
   localparam int RESP_W = 10;
   localparam int ROW_W  = 11;

   // Result queue
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [POS_W-1:0]  center_row;
      logic [POS_W-1:0]  center_col;
      logic [RESP_W-1:0] resp_0;
      logic [RESP_W-1:0] resp_1;
      logic [RESP_W-1:0] resp_2;
      logic [RESP_W-1:0] resp_3;
      logic [RESP_W-1:0] resp_4;
      logic [RESP_W-1:0] resp_5;
      logic [RESP_W-1:0] resp_6;
      logic [RESP_W-1:0] resp_7;
      logic              frame_end;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/eight_direction_gradient_maps.sv -----
// Eight-direction oriented gradient responses over a raster grey pixel stream.
//
// Input channel (req_*): one 8-bit pixel per item, raster order, rows of
// image_width pixels, frames of image_height rows. Result channel (rsp_*):
// one item per center (row j, col i) with j <= height-3 and i <= width-3,
// carrying the center position, eight clamped responses and frame_end.
// A result item is produced when pixel (j+2, i+2) is taken; it passes
// through stage 1, stage 2 and the result queue to the rsp_ ports.
// Throughput: one pixel per clock while req_stall is low. The line store is
// one synchronous RAM of MAX_WIDTH words (four rows of bytes per column),
// read on accept and written back in the following cycle, so each item costs
// one read and one write port slot per cycle.
// Reset: counters go to row 0 / col 0, width 640, height 480. The line RAM
// is then swept to zero, one column per cycle, with req_stall high; APB
// writes are taken during the sweep.
// Stall: results queue in a 4-entry buffer. Outside the sweep, req_stall
// rises only when buffer plus in-pipe items could not take one more result.
// Configuration (APB, pready always high): width at 0x0, height at 0x4,
// written by the user only while the block is idle; it is not enforced.

`default_nettype none

module eight_direction_gradient_maps #(
   parameter int MAX_WIDTH = eodg_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // pixel input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [eodg_pkg::PIX_W-1:0]    req_pixel,
   // result output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [eodg_pkg::POS_W-1:0]         rsp_center_row,
   output logic [eodg_pkg::POS_W-1:0]         rsp_center_col,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_0,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_1,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_2,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_3,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_4,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_5,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_6,
   output logic [eodg_pkg::RESP_W-1:0]        rsp_resp_7,
   output logic                               rsp_frame_end,
   // APB configuration
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [eodg_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [eodg_pkg::PDATA_W-1:0]  pwdata,
   output logic [eodg_pkg::PDATA_W-1:0]       prdata,
   output logic                               pready
);
   import eodg_pkg::*;

   // column index bits, and a width for column arithmetic that also holds
   // the 11-bit width register
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int QW = $clog2(FIFO_DEPTH + 3);
   localparam int MW = 4 * PIX_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             cfg_wr;
   reg_index_type    cfg_idx;

   assign pready  = 1'b1;
   assign cfg_idx = reg_index_type'(paddr[2]);
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_WIDTH:  prdata = PDATA_W'(width_ff);
         REG_HEIGHT: prdata = PDATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // effective sizes: width clamped to 5..MAX_WIDTH, height to >= 5
   logic [EW-1:0]    weff;
   logic [CFG_W-1:0] heff;

   always_comb begin
      if (width_ff < MIN_SIZE)
         weff = EW'(MIN_SIZE);
      else if (EW'(width_ff) > EW'(MAX_WIDTH))
         weff = EW'(MAX_WIDTH);
      else
         weff = EW'(width_ff);
      heff = (height_ff < MIN_SIZE) ? MIN_SIZE : height_ff;
   end

   // ------------------------------------------------------------------
   // Line RAM clear sweep after reset
   // ------------------------------------------------------------------
   logic          clear_ff;
   logic [CW-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == CW'(MAX_WIDTH - 1))
            clear_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Input accept and position counters
   // ------------------------------------------------------------------
   logic             req_take;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [EW-1:0]    c_cur, c_nxt;
   logic [ROW_W:0]   r_tmp, r_nxt;
   logic [ROW_W-1:0] r_cur;
   logic             pre_wrap;

   assign req_take = req_valid && !req_stall;

   always_comb begin
      // wrap left over from a size change
      pre_wrap = EW'(col_ff) >= weff;
      c_cur    = pre_wrap ? '0 : EW'(col_ff);
      r_tmp    = pre_wrap ? {1'b0, row_ff} + 1'b1 : {1'b0, row_ff};
      r_cur    = (r_tmp >= {1'b0, heff}) ? '0 : r_tmp[ROW_W-1:0];
      // advance past this pixel
      c_nxt    = c_cur + 1'b1;
      r_nxt    = {1'b0, r_cur} + 1'b1;
      if (c_nxt >= weff) begin
         col_in = '0;
         row_in = (r_nxt >= {1'b0, heff}) ? '0 : r_nxt[ROW_W-1:0];
      end else begin
         col_in = c_nxt[CW-1:0];
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_take) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line RAM read issued at accept; data back next cycle
   // ------------------------------------------------------------------
   logic             s1_valid_ff, s1_emit_ff, s1_even_ff, s1_odd_ff, s1_last_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [POS_W-1:0] s1_row_pos_ff, s1_col_pos_ff;
   logic [ROW_W-1:0] j_pos;
   logic [EW-1:0]    i_pos;

   assign j_pos = r_cur - ROW_W'(2);
   assign i_pos = c_cur - EW'(2);

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= req_take;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff   <= req_pixel;
         s1_col_ff     <= c_cur[CW-1:0];
         s1_emit_ff    <= (r_cur >= ROW_W'(2)) && (c_cur >= EW'(2));
         s1_even_ff    <= (r_cur >= ROW_W'(3)) && (c_cur >= EW'(3));
         s1_odd_ff     <= (r_cur >= ROW_W'(4)) && (c_cur >= EW'(4));
         s1_last_ff    <= (r_cur == heff - 1'b1) && (c_cur == weff - 1'b1);
         s1_row_pos_ff <= j_pos[POS_W-1:0];
         s1_col_pos_ff <= i_pos[POS_W-1:0];
      end
   end

   // one word per column: byte k is the row k+1 above the current one.
   // Same column comes back at least five items later, after its
   // write-back, so read and write never meet on one entry.
   logic [MW-1:0] line_mem [MAX_WIDTH];
   logic [MW-1:0] mem_rdata_ff, mem_wdata;
   logic [CW-1:0] mem_waddr;
   logic          mem_we;

   assign mem_we    = clear_ff || s1_valid_ff;
   assign mem_waddr = clear_ff ? clear_addr_ff : s1_col_ff;
   assign mem_wdata = clear_ff ? '0 : {mem_rdata_ff[MW-PIX_W-1:0], s1_pixel_ff};

   always_ff @(posedge clock) begin
      if (mem_we)
         line_mem[mem_waddr] <= mem_wdata;
      if (req_take)
         mem_rdata_ff <= line_mem[c_cur[CW-1:0]];
   end

   // ------------------------------------------------------------------
   // Stage 2: 5x5 window shift; row 0 is the oldest line, column 4 newest
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] win_ff [5][5];
   logic [PIX_W-1:0] col_vec [5];

   always_comb begin
      col_vec[0] = mem_rdata_ff[4*PIX_W-1:3*PIX_W];
      col_vec[1] = mem_rdata_ff[3*PIX_W-1:2*PIX_W];
      col_vec[2] = mem_rdata_ff[2*PIX_W-1:PIX_W];
      col_vec[3] = mem_rdata_ff[PIX_W-1:0];
      col_vec[4] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int k = 0; k < 5; k++) begin
            for (int m = 0; m < 4; m++)
               win_ff[k][m] <= win_ff[k][m+1];
            win_ff[k][4] <= col_vec[k];
         end
      end
   end

   logic             s2_push_ff, s2_even_ff, s2_odd_ff, s2_last_ff;
   logic [POS_W-1:0] s2_row_pos_ff, s2_col_pos_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_push_ff <= 1'b0;
      else
         s2_push_ff <= s1_valid_ff && s1_emit_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_even_ff    <= s1_even_ff;
         s2_odd_ff     <= s1_odd_ff;
         s2_last_ff    <= s1_last_ff;
         s2_row_pos_ff <= s1_row_pos_ff;
         s2_col_pos_ff <= s1_col_pos_ff;
      end
   end

   // ------------------------------------------------------------------
   // Responses from the window. Orientations 4/6 negate 0/2, and 5/7
   // negate 1/3, so four signed differences cover all eight.
   // ------------------------------------------------------------------
   localparam int SW = PIX_W + 2;

   function automatic logic [SW-1:0] sum3(input logic [PIX_W-1:0] a,
                                          input logic [PIX_W-1:0] b,
                                          input logic [PIX_W-1:0] c);
      return SW'(a) + SW'(b) + SW'(c);
   endfunction

   function automatic logic [RESP_W-1:0] clamp(input logic signed [SW:0] v,
                                               input logic on);
      logic [RESP_W-1:0] res;
      res = (on && !v[SW]) ? v[RESP_W-1:0] : '0;
      return res;
   endfunction

   logic signed [SW:0] d_vert, d_horz, d_diag_a, d_diag_b;
   rsp_type            rsp_new;

   always_comb begin
      // top minus bottom
      d_vert   = $signed({1'b0, sum3(win_ff[1][1], win_ff[1][2], win_ff[1][3])})
               - $signed({1'b0, sum3(win_ff[3][1], win_ff[3][2], win_ff[3][3])});
      // right minus left
      d_horz   = $signed({1'b0, sum3(win_ff[1][3], win_ff[2][3], win_ff[3][3])})
               - $signed({1'b0, sum3(win_ff[1][1], win_ff[2][1], win_ff[3][1])});
      // diamond lattice, right minus left of the rotated block
      d_diag_a = $signed({1'b0, sum3(win_ff[0][2], win_ff[1][3], win_ff[2][4])})
               - $signed({1'b0, sum3(win_ff[2][0], win_ff[3][1], win_ff[4][2])});
      // diamond lattice, bottom minus top of the rotated block
      d_diag_b = $signed({1'b0, sum3(win_ff[4][2], win_ff[3][3], win_ff[2][4])})
               - $signed({1'b0, sum3(win_ff[2][0], win_ff[1][1], win_ff[0][2])});

      rsp_new.center_row = s2_row_pos_ff;
      rsp_new.center_col = s2_col_pos_ff;
      rsp_new.resp_0     = clamp(d_vert, s2_even_ff);
      rsp_new.resp_4     = clamp(-d_vert, s2_even_ff);
      rsp_new.resp_2     = clamp(d_horz, s2_even_ff);
      rsp_new.resp_6     = clamp(-d_horz, s2_even_ff);
      rsp_new.resp_1     = clamp(d_diag_a, s2_odd_ff);
      rsp_new.resp_5     = clamp(-d_diag_a, s2_odd_ff);
      rsp_new.resp_3     = clamp(d_diag_b, s2_odd_ff);
      rsp_new.resp_7     = clamp(-d_diag_b, s2_odd_ff);
      rsp_new.frame_end  = s2_last_ff;
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   rsp_type        fifo_ff [FIFO_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QW-1:0]  count_ff, pending;
   logic           rsp_pop;
   rsp_type        rsp_head;

   assign rsp_valid = count_ff != '0;
   assign rsp_pop   = rsp_valid && !rsp_stall;
   assign rsp_head  = fifo_ff[rd_ptr_ff];

   // results already owed: queued plus still in the pipe
   assign pending   = count_ff + QW'(s1_valid_ff && s1_emit_ff) + QW'(s2_push_ff);
   assign req_stall = clear_ff || (pending >= QW'(FIFO_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (s2_push_ff)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QW'(s2_push_ff) - QW'(rsp_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_push_ff)
         fifo_ff[wr_ptr_ff] <= rsp_new;
   end

   assign rsp_center_row = rsp_head.center_row;
   assign rsp_center_col = rsp_head.center_col;
   assign rsp_resp_0     = rsp_head.resp_0;
   assign rsp_resp_1     = rsp_head.resp_1;
   assign rsp_resp_2     = rsp_head.resp_2;
   assign rsp_resp_3     = rsp_head.resp_3;
   assign rsp_resp_4     = rsp_head.resp_4;
   assign rsp_resp_5     = rsp_head.resp_5;
   assign rsp_resp_6     = rsp_head.resp_6;
   assign rsp_resp_7     = rsp_head.resp_7;
   assign rsp_frame_end  = rsp_head.frame_end;

endmodule

`default_nettype wire

// ----- design/eodg_checker.sv -----
`default_nettype none

module eodg_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [eodg_pkg::POS_W-1:0]  rsp_center_row,
   input wire logic [eodg_pkg::POS_W-1:0]  rsp_center_col,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_0,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_1,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_2,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_3,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_4,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_5,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_6,
   input wire logic [eodg_pkg::RESP_W-1:0] rsp_resp_7,
   input wire logic                        rsp_frame_end
);
   import eodg_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_center_row)
         && $stable(rsp_center_col) && $stable(rsp_resp_0) && $stable(rsp_resp_4)
         && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // line RAM sweep keeps the input closed right after reset
   a_sweep_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open during line clear");

   // nothing can come out in the first cycles after reset
   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result before any pixel");

   // opposite orientations are negations: at most one of each pair is nonzero
   a_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_resp_0 == '0 || rsp_resp_4 == '0)
         && (rsp_resp_2 == '0 || rsp_resp_6 == '0)
         && (rsp_resp_1 == '0 || rsp_resp_5 == '0)
         && (rsp_resp_3 == '0 || rsp_resp_7 == '0))
      else $error("opposite responses both nonzero");

endmodule

bind eight_direction_gradient_maps eodg_checker u_eodg_checker (.*);

`default_nettype wire
